>>> hdl/snf_pkg.sv
`default_nettype none

package snf_pkg;

    localparam int TABLE_BITS = 8;
    localparam int TB_EFF = (TABLE_BITS > 8) ? 8 : ((TABLE_BITS < 1) ? 1 : TABLE_BITS);

    localparam int IN_DEPTH    = 4;
    localparam int IN_PTR_W    = $clog2(IN_DEPTH);
    localparam int IN_CNT_W    = $clog2(IN_DEPTH + 1);
    localparam int OUT_DEPTH   = 8;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    localparam int ACC_W = 40;

    typedef struct packed {
        logic [15:0] weight;
        logic [15:0] source_value;
        logic        last;
    } t_term;

    typedef struct packed {
        logic [12:0] activation;
        logic [15:0] weighted_sum;
    } t_result;

    localparam logic [12:0] HALF_TABLE [0:128] = '{
        13'd1, 13'd1, 13'd2, 13'd2, 13'd2, 13'd2, 13'd2, 13'd2,
        13'd2, 13'd2, 13'd3, 13'd3, 13'd3, 13'd3, 13'd3, 13'd4,
        13'd4, 13'd4, 13'd4, 13'd5, 13'd5, 13'd5, 13'd5, 13'd6,
        13'd6, 13'd7, 13'd7, 13'd7, 13'd8, 13'd8, 13'd9, 13'd10,
        13'd10, 13'd11, 13'd11, 13'd12, 13'd13, 13'd14, 13'd15, 13'd16,
        13'd17, 13'd18, 13'd19, 13'd20, 13'd21, 13'd23, 13'd24, 13'd26,
        13'd27, 13'd29, 13'd31, 13'd33, 13'd35, 13'd37, 13'd40, 13'd42,
        13'd45, 13'd48, 13'd51, 13'd54, 13'd58, 13'd61, 13'd65, 13'd69,
        13'd74, 13'd78, 13'd83, 13'd89, 13'd94, 13'd100, 13'd106, 13'd113,
        13'd120, 13'd128, 13'd136, 13'd144, 13'd153, 13'd162, 13'd172, 13'd183,
        13'd194, 13'd206, 13'd219, 13'd232, 13'd246, 13'd261, 13'd277, 13'd293,
        13'd311, 13'd329, 13'd349, 13'd369, 13'd391, 13'd413, 13'd437, 13'd462,
        13'd488, 13'd516, 13'd545, 13'd575, 13'd606, 13'd639, 13'd674, 13'd710,
        13'd747, 13'd786, 13'd827, 13'd869, 13'd912, 13'd957, 13'd1004, 13'd1052,
        13'd1102, 13'd1153, 13'd1205, 13'd1259, 13'd1314, 13'd1370, 13'd1428, 13'd1487,
        13'd1546, 13'd1607, 13'd1668, 13'd1731, 13'd1793, 13'd1857, 13'd1920, 13'd1984,
        13'd2048
    };

    function automatic logic [7:0] table_index(input logic [15:0] q);
        logic [15:0] u;
        u = q ^ 16'h8000;
        return 8'((u >> (16 - TB_EFF)) << (8 - TB_EFF));
    endfunction

    function automatic logic [12:0] sigmoid_lookup(input logic [7:0] idx);
        logic [8:0] mirror;
        mirror = 9'd256 - {1'b0, idx};
        if (idx <= 8'd128) begin
            return HALF_TABLE[idx];
        end
        return 13'd4096 - HALF_TABLE[mirror[7:0]];
    endfunction

endpackage

`default_nettype wire

>>> hdl/snf_front.sv
`default_nettype none

module snf_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 push,
    output logic                full,
    input  wire  [15:0]         i_weight,
    input  wire  [15:0]         i_source_value,
    input  wire                 i_last,
    output logic                o_term_valid,
    output snf_pkg::t_term      o_term,
    input  wire                 i_term_pop
);

    snf_pkg::t_term                 r_mem [snf_pkg::IN_DEPTH];
    logic [snf_pkg::IN_PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [snf_pkg::IN_PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [snf_pkg::IN_CNT_W-1:0]   r_count, n_count;
    logic                           wr_en;
    logic                           rd_en;

    assign full         = (r_count == snf_pkg::IN_CNT_W'(snf_pkg::IN_DEPTH));
    assign o_term_valid = (r_count != '0);
    assign o_term       = r_mem[r_rd_ptr];
    assign wr_en        = push && !full;
    assign rd_en        = i_term_pop && o_term_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == snf_pkg::IN_PTR_W'(snf_pkg::IN_DEPTH - 1)) ? '0
                                                                          : r_wr_ptr + 1'b1;
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == snf_pkg::IN_PTR_W'(snf_pkg::IN_DEPTH - 1)) ? '0
                                                                          : r_rd_ptr + 1'b1;
        end
        unique case ({wr_en, rd_en})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= '{weight: i_weight, source_value: i_source_value, last: i_last};
        end
    end

endmodule

`default_nettype wire

>>> hdl/snf_back.sv
`default_nettype none

module snf_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_term_valid,
    input  snf_pkg::t_term      i_term,
    output logic                o_term_pop,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire  [15:0]         i_cfg_data,
    output logic                empty,
    input  wire                 pop,
    output logic [12:0]         o_activation,
    output logic [15:0]         o_weighted_sum
);

    localparam logic [snf_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(snf_pkg::ACC_W-1){1'b1}}};
    localparam logic [snf_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(snf_pkg::ACC_W-1){1'b0}}};

    logic [15:0]                    r_bias;

    logic                           r_b1_valid;
    logic                           r_b1_last;
    logic [31:0]                    r_prod;

    logic [snf_pkg::ACC_W-1:0]      r_acc;
    logic                           r_b2_valid;
    logic [snf_pkg::ACC_W-1:0]      r_sum;

    logic                           r_b3_valid;
    logic [15:0]                    r_q;

    snf_pkg::t_result               r_out_mem [snf_pkg::OUT_DEPTH];
    logic [snf_pkg::OUT_PTR_W-1:0]  r_out_wr, n_out_wr;
    logic [snf_pkg::OUT_PTR_W-1:0]  r_out_rd, n_out_rd;
    logic [snf_pkg::OUT_CNT_W-1:0]  r_out_count, n_out_count;

    logic [1:0]                     inflight;
    logic [snf_pkg::OUT_CNT_W:0]    reserved;
    logic [31:0]                    n_prod;
    logic [snf_pkg::ACC_W:0]        acc_sum;
    logic [snf_pkg::ACC_W-1:0]      acc_sat;
    logic [snf_pkg::ACC_W+1:0]      total;
    logic [29:0]                    q_full;
    logic [15:0]                    n_q;
    logic                           out_wr_en;
    logic                           out_rd_en;

    assign o_cfg_ready = 1'b1;

    // A final term may only enter when its result is sure of a slot in the output queue.
    assign inflight   = 2'(r_b1_valid && r_b1_last) + 2'(r_b2_valid) + 2'(r_b3_valid);
    assign reserved   = (snf_pkg::OUT_CNT_W + 1)'(r_out_count) + (snf_pkg::OUT_CNT_W + 1)'(inflight);
    assign o_term_pop = i_term_valid &&
                        (!i_term.last || (reserved < (snf_pkg::OUT_CNT_W + 1)'(snf_pkg::OUT_DEPTH)));

    assign n_prod = 32'($signed(i_term.weight) * $signed(i_term.source_value));

    assign acc_sum = {r_acc[snf_pkg::ACC_W-1], r_acc} + {{9{r_prod[31]}}, r_prod};

    always_comb begin
        if (acc_sum[snf_pkg::ACC_W] != acc_sum[snf_pkg::ACC_W-1]) begin
            acc_sat = acc_sum[snf_pkg::ACC_W] ? ACC_MIN : ACC_MAX;
        end else begin
            acc_sat = acc_sum[snf_pkg::ACC_W-1:0];
        end
    end

    assign total  = {{2{r_sum[snf_pkg::ACC_W-1]}}, r_sum} + {{14{r_bias[15]}}, r_bias, 12'b0};
    assign q_full = total[snf_pkg::ACC_W+1:12];

    always_comb begin
        if (q_full[29:15] == {15{q_full[29]}}) begin
            n_q = q_full[15:0];
        end else begin
            n_q = q_full[29] ? 16'h8000 : 16'h7fff;
        end
    end

    assign empty     = (r_out_count == '0);
    assign out_wr_en = r_b3_valid;
    assign out_rd_en = pop && !empty;

    assign o_activation   = r_out_mem[r_out_rd].activation;
    assign o_weighted_sum = r_out_mem[r_out_rd].weighted_sum;

    always_comb begin
        n_out_wr    = r_out_wr;
        n_out_rd    = r_out_rd;
        n_out_count = r_out_count;
        if (out_wr_en) begin
            n_out_wr = (r_out_wr == snf_pkg::OUT_PTR_W'(snf_pkg::OUT_DEPTH - 1)) ? '0
                                                                            : r_out_wr + 1'b1;
        end
        if (out_rd_en) begin
            n_out_rd = (r_out_rd == snf_pkg::OUT_PTR_W'(snf_pkg::OUT_DEPTH - 1)) ? '0
                                                                            : r_out_rd + 1'b1;
        end
        unique case ({out_wr_en, out_rd_en})
            2'b10:   n_out_count = r_out_count + 1'b1;
            2'b01:   n_out_count = r_out_count - 1'b1;
            default: n_out_count = r_out_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias      <= '0;
            r_b1_valid  <= 1'b0;
            r_b1_last   <= 1'b0;
            r_acc       <= '0;
            r_b2_valid  <= 1'b0;
            r_b3_valid  <= 1'b0;
            r_out_wr    <= '0;
            r_out_rd    <= '0;
            r_out_count <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_bias <= i_cfg_data;
            end
            r_b1_valid <= o_term_pop;
            r_b1_last  <= o_term_pop && i_term.last;
            r_b2_valid <= r_b1_valid && r_b1_last;
            if (r_b1_valid) begin
                r_acc <= r_b1_last ? '0 : acc_sat;
            end
            r_b3_valid  <= r_b2_valid;
            r_out_wr    <= n_out_wr;
            r_out_rd    <= n_out_rd;
            r_out_count <= n_out_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        if (r_b1_valid && r_b1_last) begin
            r_sum <= acc_sat;
        end
        r_q <= n_q;
        if (out_wr_en) begin
            r_out_mem[r_out_wr] <= '{activation:   snf_pkg::sigmoid_lookup(snf_pkg::table_index(r_q)),
                                     weighted_sum: r_q};
        end
    end

endmodule

`default_nettype wire

>>> hdl/sigmoid_neuron_forward_top.sv
// Forward value of one logistic neuron in fixed point.
// Terms enter through a queue-style port: push with i_weight, i_source_value and
// i_last; a transfer happens on a rising edge with push high and full low. One term
// may be transferred in every cycle while full is low; a four-entry queue holds terms while the back end
// waits for room for a result.
// Results leave through a second queue: while empty is low, o_activation and
// o_weighted_sum show the oldest result, and a transfer happens with pop high.
// After the transfer of its final term, a result passes the multiply, accumulate
// and bias-and-narrow registers and is then written to the output queue.
// The output queue holds eight results. When the receiver stalls, final terms are held
// back until a slot is reserved, and the input queue then fills and raises full.
// The bias register is written through i_cfg_valid and i_cfg_data; o_cfg_ready is
// always high. Write it only while no term is pending.
// Synchronous reset clears both queues, the accumulator and the bias.
`default_nettype none

module sigmoid_neuron_forward_top (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          push,
    output logic         full,
    input  wire  [15:0]  i_weight,
    input  wire  [15:0]  i_source_value,
    input  wire          i_last,
    output logic         empty,
    input  wire          pop,
    output logic [12:0]  o_activation,
    output logic [15:0]  o_weighted_sum,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [15:0]  i_cfg_data
);

    logic               term_valid;
    snf_pkg::t_term     term;
    logic               term_pop;

    snf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_weight       (i_weight),
        .i_source_value (i_source_value),
        .i_last         (i_last),
        .o_term_valid   (term_valid),
        .o_term         (term),
        .i_term_pop     (term_pop)
    );

    snf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_term_valid   (term_valid),
        .i_term         (term),
        .o_term_pop     (term_pop),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .empty          (empty),
        .pop            (pop),
        .o_activation   (o_activation),
        .o_weighted_sum (o_weighted_sum)
    );

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    a_activation_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_activation <= 13'd4096))
        else $error("activation above one");

    a_sign_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_weighted_sum[15] == (o_activation < 13'd2048)))
        else $error("activation disagrees with the sign of the sum");

    a_term_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (term_pop && !term.last) |-> term_valid)
        else $error("term taken from an empty queue");

endmodule

`default_nettype wire

>>> tb/sigmoid_neuron_forward_top_tb.sv
`default_nettype none

module sigmoid_neuron_forward_top_tb;

    localparam int TBITS = (snf_pkg::TABLE_BITS > 8) ? 8 :
                           ((snf_pkg::TABLE_BITS < 1) ? 1 : snf_pkg::TABLE_BITS);
    localparam longint ACC_MAX = (longint'(1) <<< 39) - 1;
    localparam longint ACC_MIN = -(longint'(1) <<< 39);
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 12;

    localparam logic [12:0] SIGMOID_HALF [0:128] = '{
        13'd1, 13'd1, 13'd2, 13'd2, 13'd2, 13'd2, 13'd2, 13'd2,
        13'd2, 13'd2, 13'd3, 13'd3, 13'd3, 13'd3, 13'd3, 13'd4,
        13'd4, 13'd4, 13'd4, 13'd5, 13'd5, 13'd5, 13'd5, 13'd6,
        13'd6, 13'd7, 13'd7, 13'd7, 13'd8, 13'd8, 13'd9, 13'd10,
        13'd10, 13'd11, 13'd11, 13'd12, 13'd13, 13'd14, 13'd15, 13'd16,
        13'd17, 13'd18, 13'd19, 13'd20, 13'd21, 13'd23, 13'd24, 13'd26,
        13'd27, 13'd29, 13'd31, 13'd33, 13'd35, 13'd37, 13'd40, 13'd42,
        13'd45, 13'd48, 13'd51, 13'd54, 13'd58, 13'd61, 13'd65, 13'd69,
        13'd74, 13'd78, 13'd83, 13'd89, 13'd94, 13'd100, 13'd106, 13'd113,
        13'd120, 13'd128, 13'd136, 13'd144, 13'd153, 13'd162, 13'd172, 13'd183,
        13'd194, 13'd206, 13'd219, 13'd232, 13'd246, 13'd261, 13'd277, 13'd293,
        13'd311, 13'd329, 13'd349, 13'd369, 13'd391, 13'd413, 13'd437, 13'd462,
        13'd488, 13'd516, 13'd545, 13'd575, 13'd606, 13'd639, 13'd674, 13'd710,
        13'd747, 13'd786, 13'd827, 13'd869, 13'd912, 13'd957, 13'd1004, 13'd1052,
        13'd1102, 13'd1153, 13'd1205, 13'd1259, 13'd1314, 13'd1370, 13'd1428, 13'd1487,
        13'd1546, 13'd1607, 13'd1668, 13'd1731, 13'd1793, 13'd1857, 13'd1920, 13'd1984,
        13'd2048
    };

    typedef struct packed {
        logic [12:0] activation;
        logic [15:0] weighted_sum;
    } t_neuron_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [15:0] i_weight = '0;
    logic [15:0] i_source_value = '0;
    logic        i_last = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [12:0] o_activation;
    logic [15:0] o_weighted_sum;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    longint      neuron_sum = 0;
    logic [15:0] bias_reg = '0;
    t_neuron_out outputs_due [$];
    int          mismatch_count = 0;
    int          stall_cycles = 0;
    bit          steady = 1'b0;

    sigmoid_neuron_forward_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_weight       (i_weight),
        .i_source_value (i_source_value),
        .i_last         (i_last),
        .empty          (empty),
        .pop            (pop),
        .o_activation   (o_activation),
        .o_weighted_sum (o_weighted_sum),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic bit accumulate_term(input logic [15:0] w, input logic [15:0] x,
                                           input logic l, output t_neuron_out r);
        longint total;
        longint q;
        longint idx;
        logic [12:0] act;
        neuron_sum = neuron_sum + longint'($signed(w)) * longint'($signed(x));
        if (neuron_sum > ACC_MAX) begin
            neuron_sum = ACC_MAX;
        end else if (neuron_sum < ACC_MIN) begin
            neuron_sum = ACC_MIN;
        end
        r = '0;
        if (!l) begin
            return 1'b0;
        end
        total = neuron_sum + longint'($signed(bias_reg)) * 4096;
        q = total >>> 12;
        if (q > 32767) begin
            q = 32767;
        end else if (q < -32768) begin
            q = -32768;
        end
        idx = (((q + 32768) >> (16 - TBITS)) << (8 - TBITS)) & 255;
        if (idx <= 128) begin
            act = SIGMOID_HALF[idx];
        end else begin
            act = 13'd4096 - SIGMOID_HALF[256 - idx];
        end
        r.activation = act;
        r.weighted_sum = q[15:0];
        neuron_sum = 0;
        return 1'b1;
    endfunction

    function automatic logic [15:0] rand_q412();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 8) begin
            case ($urandom_range(3))
                0: return 16'h8000;
                1: return 16'h7fff;
                2: return 16'h0000;
                default: return 16'hffff;
            endcase
        end
        if (sel < 50) begin
            return 16'($urandom);
        end
        return 16'($urandom_range(16383)) - 16'd8192;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 50) begin
            $display("error at %0t: %s got %0d, wanted %0d", $time, what, got, want);
        end
    endtask

    task automatic send_term(input logic [15:0] w, input logic [15:0] x, input logic l);
        t_neuron_out r;
        while (!steady && $urandom_range(99) < 36) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_weight <= w;
        i_source_value <= x;
        i_last <= l;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        if (accumulate_term(w, x, l, r)) begin
            outputs_due.insert(outputs_due.size(), r);
        end
    endtask

    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        while (outputs_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_bias(input logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        bias_reg = v;
    endtask

    task automatic test_extremes();
        send_term(16'h7fff, 16'h7fff, 1'b1);
        send_term(16'h8000, 16'h8000, 1'b1);
        send_term(16'h8000, 16'h7fff, 1'b1);
        send_term(16'h0000, 16'h0000, 1'b1);
        send_term(16'h0001, 16'h0001, 1'b1);
        send_term(16'hffff, 16'h0001, 1'b1);
        send_term(16'hffff, 16'hffff, 1'b1);
        send_term(16'h1000, 16'h1000, 1'b1);
        send_term(16'h0100, 16'h1000, 1'b1);
        send_term(16'h0010, 16'h1000, 1'b1);
        send_term(16'hfff0, 16'h1000, 1'b1);
        send_term(16'h1000, 16'h8000, 1'b1);
        send_term(16'h7fff, 16'h0001, 1'b0);
        send_term(16'h8000, 16'h0001, 1'b0);
        send_term(16'h0003, 16'h1000, 1'b1);
        drain_results();
    endtask

    task automatic test_bias();
        write_bias(16'h7fff);
        send_term(16'h0000, 16'h0000, 1'b1);
        send_term(16'h7fff, 16'h7fff, 1'b1);
        send_term(16'h8000, 16'h7fff, 1'b1);
        drain_results();
        write_bias(16'h8000);
        send_term(16'h0000, 16'h0000, 1'b1);
        send_term(16'h8000, 16'h8000, 1'b1);
        send_term(16'h8000, 16'h7fff, 1'b1);
        drain_results();
        write_bias(16'h0800);
        send_term(16'h0000, 16'h0000, 1'b1);
        send_term(16'hf000, 16'h1000, 1'b1);
        drain_results();
        write_bias(16'h0000);
    endtask

    // The sum is driven past the upper 40-bit bound, so that a wrapped accumulator
    // would turn negative and give a different result.
    task automatic test_acc_saturation();
        steady = 1'b1;
        repeat (513) send_term(16'h8000, 16'h8000, 1'b0);
        send_term(16'h8000, 16'h8000, 1'b1);
        steady = 1'b0;
        drain_results();
    endtask

    task automatic test_random();
        int n;
        int glen;
        logic [15:0] b;
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                1: b = 16'h7fff;
                2: b = 16'h8000;
                3: b = 16'h0000;
                5: b = 16'($urandom_range(4095)) - 16'd2048;
                default: b = 16'($urandom);
            endcase
            write_bias(b);
            steady = (phase == 2);
            n = 0;
            while (n < 8) begin
                if ($urandom_range(9) == 0) begin
                    glen = $urandom_range(40, 12);
                end else begin
                    glen = $urandom_range(8, 1);
                end
                for (int k = 0; k < glen; k++) begin
                    send_term(rand_q412(), rand_q412(), k == glen - 1);
                    n++;
                end
            end
            // An open neuron is left in odd phases and carried across the next bias write, if any.
            if (phase % 2 == 1) begin
                send_term(rand_q412(), rand_q412(), 1'b0);
            end
            steady = 1'b0;
            drain_results();
        end
        send_term(rand_q412(), rand_q412(), 1'b1);
        drain_results();
    endtask

    always @(posedge i_clk) begin
        pop <= steady || ($urandom_range(99) >= 36);
    end

    always @(posedge i_clk) begin : check_results
        t_neuron_out want;
        if (i_rst_n && pop && !empty) begin
            if (outputs_due.size() == 0) begin
                report_mismatch("unexpected result, weighted_sum", $signed(o_weighted_sum), 0);
            end else begin
                want = outputs_due.pop_front();
                if (o_activation !== want.activation) begin
                    report_mismatch("activation", o_activation, want.activation);
                end
                if (o_weighted_sum !== want.weighted_sum) begin
                    report_mismatch("weighted_sum", $signed(o_weighted_sum),
                                    $signed(want.weighted_sum));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_bias();
        test_acc_saturation();
        test_random();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
hdl/snf_pkg.sv
hdl/snf_front.sv
hdl/snf_back.sv
hdl/sigmoid_neuron_forward_top.sv
tb/sigmoid_neuron_forward_top_tb.sv
